### src/spr_anim_pkg.sv
package spr_anim_pkg;

   // Table geometry.
   localparam int MAX_SEQUENCES = 64;
   localparam int MAX_FRAMES = 64;
   localparam int IMAGE_BITS = 10;
   localparam int SEQ_BITS = $clog2(MAX_SEQUENCES);
   localparam int FRAME_BITS = $clog2(MAX_FRAMES);
   localparam int COUNT_BITS = $clog2(MAX_FRAMES + 1);
   localparam int IMG_ADDR_BITS = SEQ_BITS + FRAME_BITS;

   // Division by 100 is done as a multiply by ceil(2^30 / 100) and a shift by 30.
   // This is exact for every magnitude below 2^23.
   localparam logic [23:0] RECIP_100 = 24'd10737419;
   localparam int RECIP_SHIFT = 30;

   // Action codes of the request channel.
   typedef enum logic [3:0] {
      ACT_TICK        = 4'd0,
      ACT_PLAY        = 4'd1,
      ACT_STOP        = 4'd2,
      ACT_REWIND      = 4'd3,
      ACT_NEXT        = 4'd4,
      ACT_PREV        = 4'd5,
      ACT_SET_SEQ     = 4'd6,
      ACT_SET_FRAME   = 4'd7,
      ACT_SET_SPEED   = 4'd8,
      ACT_SET_LERP    = 4'd9,
      ACT_RESET_SPEED = 4'd10,
      ACT_LOAD_SEQ    = 4'd11,
      ACT_LOAD_IMAGE  = 4'd12
   } action_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_LERP_MUL,
      ST_LERP_DIV,
      ST_SPEED,
      ST_TICK_MUL,
      ST_TICK_SCALE,
      ST_TICK_ADD,
      ST_ADVANCE,
      ST_OUT,
      ST_HOLD
   } state_type;

   // One row of the sequence table.
   typedef struct packed {
      logic signed [15:0]    high;
      logic signed [15:0]    low;
      logic [FRAME_BITS-1:0] loop;
      logic [COUNT_BITS-1:0] frames;
   } seq_row_type;

   // Write and read requests to the table storage.
   typedef struct packed {
      logic                     row_we;
      logic [SEQ_BITS-1:0]      row_waddr;
      seq_row_type              row_wdata;
      logic [SEQ_BITS-1:0]      row_raddr;
      logic                     img_we;
      logic [IMG_ADDR_BITS-1:0] img_waddr;
      logic [IMAGE_BITS-1:0]    img_wdata;
      logic [IMG_ADDR_BITS-1:0] img_raddr;
   } tab_req_type;

endpackage

### src/spr_anim_tables.sv
module spr_anim_tables (
   input  logic                                 clock,
   input  spr_anim_pkg::tab_req_type            tab_req,
   output spr_anim_pkg::seq_row_type            row_rd,
   output logic [spr_anim_pkg::IMAGE_BITS-1:0]  img_rd
);
   import spr_anim_pkg::*;

   seq_row_type           row_mem [MAX_SEQUENCES];
   logic [IMAGE_BITS-1:0] img_mem [MAX_SEQUENCES * MAX_FRAMES];
   seq_row_type           row_q_ff;
   logic [IMAGE_BITS-1:0] img_q_ff;

   // Sequence rows: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tab_req.row_we) begin
         row_mem[tab_req.row_waddr] <= tab_req.row_wdata;
      end
      row_q_ff <= row_mem[tab_req.row_raddr];
   end

   // Image numbers, addressed by sequence and frame.
   always_ff @(posedge clock) begin
      if (tab_req.img_we) begin
         img_mem[tab_req.img_waddr] <= tab_req.img_wdata;
      end
      img_q_ff <= img_mem[tab_req.img_raddr];
   end

   assign row_rd = row_q_ff;
   assign img_rd = img_q_ff;

endmodule

### src/sprite_animation_sequencer.sv
// Sprite animation sequencer.
// Requests arrive on the req_ channel (valid/stall); each accepted request
// produces exactly one response on the rsp_ channel (valid/stall), which
// reports the image of the current frame and the playback state after it.
// The csr_ channel writes the sequence count; it is always ready and should
// only be written while no request is in flight.
// The block handles one request at a time and stalls the request channel
// until the response transfer completes. A tick while playing adds the
// timer arithmetic and the frame walk, which steps one frame per cycle.
// All speed and timer multiplications run through one shared multiplier,
// used twice for every request and twice more for a tick while playing.
// A stalled response holds its payload and keeps the block busy.
// Reset returns the playback state and speeds to their defaults and the
// sequence count to 1; the sequence and image tables are not cleared and
// must be loaded before they are used.
module sprite_animation_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_action,
   input  logic [15:0]        req_delta_time,
   input  logic signed [7:0]  req_seq_index,
   input  logic signed [7:0]  req_frame_index,
   input  logic signed [15:0] req_speed_value,
   input  logic signed [15:0] req_alt_speed_value,
   input  logic [6:0]         req_lerp_value,
   input  logic               req_lerp_on,
   input  logic [5:0]         req_loop_target,
   input  logic [6:0]         req_frame_count,
   input  logic [9:0]         req_image_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_image_index,
   output logic               rsp_image_valid,
   output logic [5:0]         rsp_frame_now,
   output logic [5:0]         rsp_sequence_now,
   output logic               rsp_playing,
   output logic               rsp_finished,
   output logic signed [15:0] rsp_effective_speed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_sequence_count
);
   import spr_anim_pkg::*;

   // Sequencer and captured request.
   state_type             state_ff, state_in;
   action_type            act_ff;
   logic [15:0]           delta_ff;
   logic signed [7:0]     sidx_ff;
   logic signed [7:0]     fidx_ff;
   logic signed [15:0]    spd_ff;
   logic signed [15:0]    alt_ff;
   logic [6:0]            lerpv_ff;
   logic                  lon_ff;
   logic [5:0]            loopt_ff;
   logic [6:0]            fcnt_ff;
   logic [9:0]            imgno_ff;

   // Playback state.
   logic [6:0]            count_ff;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic signed [31:0]    timer_ff, timer_in;
   logic signed [15:0]    ovr_spd_ff, ovr_spd_in;
   logic                  ovr_act_ff, ovr_act_in;
   logic signed [15:0]    high_ff, high_in;
   logic signed [15:0]    low_ff, low_in;
   logic [6:0]            lerp_ff, lerp_in;
   logic                  lerp_act_ff, lerp_act_in;
   logic signed [15:0]    eff_ff, eff_in;
   logic [55:0]           mul_ff, mul_in;

   // Response registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [9:0]            rsp_img_ff, rsp_img_in;
   logic                  rsp_imgv_ff, rsp_imgv_in;

   // Table storage.
   tab_req_type           tab_req;
   seq_row_type           row_rd;
   logic [IMAGE_BITS-1:0] img_rd;

   // Combinational helpers.
   logic [6:0]            count_force;
   logic [SEQ_BITS-1:0]   seq_sel;
   logic [COUNT_BITS-1:0] adv_inc;
   logic [FRAME_BITS-1:0] adv_frame;
   logic                  adv_wrap;
   logic signed [16:0]    diff;
   logic [16:0]           diff_mag;
   logic [16:0]           eff_mag;
   logic signed [17:0]    lerp_term;
   logic signed [17:0]    lerp_speed;
   logic [22:0]           inc_mag;
   logic signed [33:0]    timer_sum;
   logic [31:0]           mul_a;
   logic [23:0]           mul_b;
   logic                  tick_run;

   spr_anim_tables u_tables (
      .clock   (clock),
      .tab_req (tab_req),
      .row_rd  (row_rd),
      .img_rd  (img_rd)
   );

   // Sequence count in force and the sequence that set_seq selects.
   assign count_force = (count_ff > 7'(MAX_SEQUENCES)) ? 7'(MAX_SEQUENCES) : count_ff;
   assign seq_sel = (!sidx_ff[7] && (7'(sidx_ff[6:0]) < count_force)) ?
                    sidx_ff[SEQ_BITS-1:0] : '0;

   // Frame advance with wrap to the loop target, or to frame 0 if the target is out of range.
   assign adv_inc  = COUNT_BITS'(frame_ff) + COUNT_BITS'(1);
   assign adv_wrap = adv_inc >= row_rd.frames;
   always_comb begin
      if (!adv_wrap) begin
         adv_frame = adv_inc[FRAME_BITS-1:0];
      end else if (COUNT_BITS'(row_rd.loop) >= row_rd.frames) begin
         adv_frame = '0;
      end else begin
         adv_frame = row_rd.loop;
      end
   end

   // Speed arithmetic around the shared multiplier.
   assign diff       = 17'(high_ff) - 17'(low_ff);
   assign diff_mag   = diff[16] ? 17'(-diff) : 17'(diff);
   assign eff_mag    = eff_ff[15] ? 17'(-17'(eff_ff)) : 17'(eff_ff);
   assign lerp_term  = diff[16] ? -18'($signed({1'b0, mul_ff[46:30]})) :
                       18'($signed({1'b0, mul_ff[46:30]}));
   assign lerp_speed = 18'(low_ff) + lerp_term;
   assign inc_mag    = mul_ff[38:16];
   assign timer_sum  = 34'(timer_ff) +
                       (eff_ff[15] ? -34'($signed({1'b0, inc_mag})) :
                        34'($signed({1'b0, inc_mag})));
   assign tick_run   = (act_ff == ACT_TICK) && run_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_LERP_MUL: begin
            mul_a = 32'(diff_mag);
            mul_b = 24'(lerp_ff);
         end
         ST_LERP_DIV: begin
            mul_a = 32'(mul_ff[22:0]);
            mul_b = RECIP_100;
         end
         ST_TICK_MUL: begin
            mul_a = 32'(eff_mag);
            mul_b = 24'(delta_ff);
         end
         ST_TICK_SCALE: begin
            mul_a = mul_ff[31:0];
            mul_b = 24'd100;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_FETCH;
         ST_FETCH:      state_in = ST_EXEC;
         ST_EXEC:       state_in = ST_LERP_MUL;
         ST_LERP_MUL:   state_in = ST_LERP_DIV;
         ST_LERP_DIV:   state_in = ST_SPEED;
         ST_SPEED:      state_in = tick_run ? ST_TICK_MUL : ST_OUT;
         ST_TICK_MUL:   state_in = ST_TICK_SCALE;
         ST_TICK_SCALE: state_in = ST_TICK_ADD;
         ST_TICK_ADD:   state_in = ST_ADVANCE;
         ST_ADVANCE:    if (timer_ff <= 32'sd100) state_in = ST_OUT;
         ST_OUT:        state_in = ST_HOLD;
         ST_HOLD:       if (!rsp_stall) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and table requests per state.
   always_comb begin
      run_in       = run_ff;
      done_in      = done_ff;
      seq_in       = seq_ff;
      frame_in     = frame_ff;
      timer_in     = timer_ff;
      ovr_spd_in   = ovr_spd_ff;
      ovr_act_in   = ovr_act_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      lerp_in      = lerp_ff;
      lerp_act_in  = lerp_act_ff;
      eff_in       = eff_ff;
      mul_in       = mul_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_img_in   = rsp_img_ff;
      rsp_imgv_in  = rsp_imgv_ff;

      tab_req.row_we           = 1'b0;
      tab_req.row_waddr        = sidx_ff[SEQ_BITS-1:0];
      tab_req.row_wdata.high   = spd_ff;
      tab_req.row_wdata.low    = alt_ff;
      tab_req.row_wdata.loop   = loopt_ff;
      tab_req.row_wdata.frames = (fcnt_ff > 7'(MAX_FRAMES)) ? COUNT_BITS'(MAX_FRAMES) :
                                 COUNT_BITS'(fcnt_ff);
      tab_req.row_raddr        = seq_ff;
      tab_req.img_we           = 1'b0;
      tab_req.img_waddr        = {sidx_ff[SEQ_BITS-1:0], fidx_ff[FRAME_BITS-1:0]};
      tab_req.img_wdata        = imgno_ff;
      tab_req.img_raddr        = {seq_ff, frame_ff};

      unique case (state_ff)
         // Table writes and the row read for the action.
         ST_FETCH: begin
            if (act_ff == ACT_SET_SEQ) begin
               tab_req.row_raddr = seq_sel;
            end
            if (act_ff == ACT_LOAD_SEQ && sidx_ff[7:SEQ_BITS] == '0) begin
               tab_req.row_we = 1'b1;
            end
            if (act_ff == ACT_LOAD_IMAGE && sidx_ff[7:SEQ_BITS] == '0 &&
                fidx_ff[7:FRAME_BITS] == '0) begin
               tab_req.img_we = 1'b1;
            end
         end
         // Apply the action to the playback state.
         ST_EXEC: begin
            unique case (act_ff)
               ACT_TICK: if (run_ff) done_in = 1'b0;
               ACT_PLAY: run_in = 1'b1;
               ACT_STOP: run_in = 1'b0;
               ACT_REWIND: begin
                  frame_in = '0;
                  timer_in = '0;
                  done_in  = 1'b0;
               end
               ACT_NEXT: begin
                  frame_in = adv_frame;
                  timer_in = '0;
               end
               ACT_PREV: begin
                  if (frame_ff != '0) begin
                     frame_in = frame_ff - FRAME_BITS'(1);
                  end else if (row_rd.frames != '0) begin
                     frame_in = FRAME_BITS'(row_rd.frames - COUNT_BITS'(1));
                  end else begin
                     frame_in = '0;
                  end
                  timer_in = '0;
               end
               ACT_SET_SEQ: begin
                  done_in     = 1'b0;
                  run_in      = 1'b1;
                  seq_in      = seq_sel;
                  frame_in    = '0;
                  timer_in    = '0;
                  ovr_act_in  = 1'b0;
                  ovr_spd_in  = '0;
                  high_in     = row_rd.high;
                  low_in      = row_rd.low;
                  lerp_act_in = 1'b0;
               end
               ACT_SET_FRAME: begin
                  if (!fidx_ff[7] && (COUNT_BITS'(fidx_ff[6:0]) < row_rd.frames)) begin
                     frame_in = fidx_ff[FRAME_BITS-1:0];
                  end else begin
                     frame_in = '0;
                  end
                  timer_in = '0;
               end
               ACT_SET_SPEED: begin
                  ovr_spd_in = spd_ff;
                  ovr_act_in = 1'b1;
               end
               ACT_SET_LERP: begin
                  if (lon_ff) begin
                     lerp_in     = (lerpv_ff > 7'd100) ? 7'd100 : lerpv_ff;
                     lerp_act_in = 1'b1;
                  end else begin
                     lerp_act_in = 1'b0;
                  end
               end
               ACT_RESET_SPEED: ovr_act_in = 1'b0;
               default: begin
               end
            endcase
         end
         ST_LERP_MUL, ST_LERP_DIV, ST_TICK_MUL, ST_TICK_SCALE: begin
            mul_in = 56'(mul_a) * 56'(mul_b);
         end
         // Effective speed: override, else interpolated, else high.
         ST_SPEED: begin
            if (ovr_act_ff) begin
               eff_in = ovr_spd_ff;
            end else if (lerp_act_ff) begin
               eff_in = lerp_speed[15:0];
            end else begin
               eff_in = high_ff;
            end
         end
         // Saturating timer update.
         ST_TICK_ADD: begin
            if (timer_sum[33:31] == 3'b000 || timer_sum[33:31] == 3'b111) begin
               timer_in = timer_sum[31:0];
            end else if (timer_sum[33]) begin
               timer_in = 32'sh8000_0000;
            end else begin
               timer_in = 32'sh7FFF_FFFF;
            end
         end
         // One frame per cycle while the timer exceeds one frame period.
         ST_ADVANCE: begin
            if (timer_ff > 32'sd100) begin
               timer_in = timer_ff - 32'sd100;
               frame_in = adv_frame;
               if (adv_wrap) done_in = 1'b1;
            end
         end
         // Build the response from the rows read for the current position.
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            if (count_force == '0 || 7'(seq_ff) >= count_force || row_rd.frames == '0) begin
               rsp_img_in  = '0;
               rsp_imgv_in = 1'b0;
            end else begin
               rsp_img_in  = (COUNT_BITS'(frame_ff) < row_rd.frames) ? img_rd : '0;
               rsp_imgv_in = 1'b1;
            end
         end
         ST_HOLD: if (!rsp_stall) rsp_valid_in = 1'b0;
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 7'd1;
         run_ff       <= 1'b0;
         done_ff      <= 1'b0;
         seq_ff       <= '0;
         frame_ff     <= '0;
         timer_ff     <= '0;
         ovr_spd_ff   <= '0;
         ovr_act_ff   <= 1'b0;
         high_ff      <= 16'sd100;
         low_ff       <= 16'sd100;
         lerp_ff      <= '0;
         lerp_act_ff  <= 1'b0;
         eff_ff       <= 16'sd100;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) count_ff <= csr_sequence_count;
         run_ff       <= run_in;
         done_ff      <= done_in;
         seq_ff       <= seq_in;
         frame_ff     <= frame_in;
         timer_ff     <= timer_in;
         ovr_spd_ff   <= ovr_spd_in;
         ovr_act_ff   <= ovr_act_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         lerp_ff      <= lerp_in;
         lerp_act_ff  <= lerp_act_in;
         eff_ff       <= eff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         act_ff   <= action_type'(req_action);
         delta_ff <= req_delta_time;
         sidx_ff  <= req_seq_index;
         fidx_ff  <= req_frame_index;
         spd_ff   <= req_speed_value;
         alt_ff   <= req_alt_speed_value;
         lerpv_ff <= req_lerp_value;
         lon_ff   <= req_lerp_on;
         loopt_ff <= req_loop_target;
         fcnt_ff  <= req_frame_count;
         imgno_ff <= req_image_number;
      end
      mul_ff      <= mul_in;
      rsp_img_ff  <= rsp_img_in;
      rsp_imgv_ff <= rsp_imgv_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_image_index     = rsp_img_ff;
   assign rsp_image_valid     = rsp_imgv_ff;
   assign rsp_frame_now       = frame_ff;
   assign rsp_sequence_now    = seq_ff;
   assign rsp_playing         = run_ff;
   assign rsp_finished        = done_ff;
   assign rsp_effective_speed = eff_ff;

   // An accepted request always starts the table fetch.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_FETCH))
      else $error("request transfer did not start the fetch");

   // The frame walk always leaves the timer at or below one frame period.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (timer_ff <= 32'sd100))
      else $error("timer above one frame period at response");

   // A response is only presented while the sequencer holds it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_HOLD))
      else $error("response valid outside the hold state");

   // The timer multiply of the shared multiplier is only entered for a running tick.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_MUL) |-> (act_ff == ACT_TICK && run_ff))
      else $error("timer arithmetic started without a running tick");

endmodule
